>>> hw/rtl/dpq_pkg.sv
// Shared types and constants for the deadline priority queue.
// Holds beat structs, command/status/state codes and slot word layout.
// No dependencies.
package dpq_pkg;

    localparam int CAPACITY      = 64;
    localparam int DEADLINE_BITS = 48;
    localparam int ID_BITS       = 32;
    localparam int SLOT_BITS     = $clog2(CAPACITY);
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN1,
        ST_APPLY,
        ST_SCAN2,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd                     cmd;
        logic [DEADLINE_BITS-1:0] deadline;
        logic [ID_BITS-1:0]       item_id;
    } t_cmd_beat;

    typedef struct packed {
        t_status                  status;
        logic [DEADLINE_BITS-1:0] head_deadline;
        logic [ID_BITS-1:0]       head_id;
        logic                     head_valid;
        logic [CNT_BITS-1:0]      entry_count;
    } t_rsp_beat;

    // One storage slot as kept in the slot memory
    typedef struct packed {
        logic                     valid;
        logic [ID_BITS-1:0]       item_id;
        logic [DEADLINE_BITS-1:0] deadline;
    } t_slot;

endpackage

>>> hw/rtl/dpq_slot_ram.sv
// Slot memory: one write port and one read port, registered read data.
// Depends on dpq_pkg for the slot word layout.
module dpq_slot_ram
    import dpq_pkg::*;
#(
    parameter int DEPTH = CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_slot                    i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_slot                    o_rd_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    // Write the addressed slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read of the addressed slot
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/deadline_priority_queue_with_cancel_top.sv
// Deadline priority queue with cancel by id, slots held in one synchronous memory.
// A pop does a read sweep for the head, then its write, then loads its result beat; add,
// remove and status do a read sweep for id/free/head, at most one write, then a head sweep.
// Only one command is in flight: the next is accepted once the result beat is loaded, which
// waits while a held result beat is stalled. Depends on dpq_pkg and dpq_slot_ram.
// Reset: a clearing pass over every slot zeroes each slot valid bit; input stalls until it ends.
module deadline_priority_queue_with_cancel_top
    import dpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_cmd_beat i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_rsp_beat o_out_data
);

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(CAPACITY - 1);

    t_state r_state;
    t_state n_state;

    // Sweep control
    logic [SLOT_BITS-1:0] r_addr;
    logic                 r_issue;
    logic                 r_rd_vld;
    logic [SLOT_BITS-1:0] r_rd_idx;

    // Captured command and sweep results
    t_cmd_beat                r_cmd;
    logic                     r_match_hit;
    logic [SLOT_BITS-1:0]     r_match_slot;
    logic                     r_free_hit;
    logic [SLOT_BITS-1:0]     r_free_slot;
    logic                     r_head_hit;
    logic [SLOT_BITS-1:0]     r_head_slot;
    logic [DEADLINE_BITS-1:0] r_head_dl;
    logic [ID_BITS-1:0]       r_head_id;
    t_status                  r_status;
    logic [CNT_BITS-1:0]      r_count;

    logic      r_out_valid;
    t_rsp_beat r_out_data;

    // Memory ports
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    t_slot                wr_data;
    t_slot                rd_slot;

    // Control decodes
    logic    accept;
    logic    scanning;
    logic    sweep_end;
    logic    start_sweep;
    logic    load_out;
    logic    cnt_inc;
    logic    cnt_dec;
    t_status apply_status;
    logic    match_now;
    logic    free_now;
    logic    head_now;

    dpq_slot_ram #(
        .DEPTH(CAPACITY)
    ) u_slot_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_slot)
    );

    // Compare the slot coming back from memory
    assign scanning  = (r_state == ST_SCAN1) || (r_state == ST_SCAN2);
    assign sweep_end = scanning && r_rd_vld && (r_rd_idx == SLOT_LAST);
    assign match_now = r_rd_vld && rd_slot.valid && (rd_slot.item_id == r_cmd.item_id);
    assign free_now  = r_rd_vld && !rd_slot.valid;
    assign head_now  = r_rd_vld && rd_slot.valid &&
                       (!r_head_hit || (rd_slot.deadline < r_head_dl));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == SLOT_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN1;
            end
            ST_SCAN1: begin
                if (sweep_end) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (r_cmd.cmd == CMD_POP) n_state = ST_DONE;
                else n_state = ST_SCAN2;
            end
            ST_SCAN2: begin
                if (sweep_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer: memory write, handshake, count update
    always_comb begin
        o_in_stall   = 1'b1;
        accept       = 1'b0;
        start_sweep  = 1'b0;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = '0;
        cnt_inc      = 1'b0;
        cnt_dec      = 1'b0;
        apply_status = STS_OK;
        case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                accept      = i_in_valid;
                start_sweep = i_in_valid;
            end
            ST_APPLY: begin
                start_sweep = (r_cmd.cmd != CMD_POP);
                case (r_cmd.cmd)
                    CMD_ADD: begin
                        wr_data = '{valid: 1'b1, item_id: r_cmd.item_id,
                                    deadline: r_cmd.deadline};
                        if (r_match_hit) begin
                            wr_en   = 1'b1;
                            wr_addr = r_match_slot;
                        end else if (r_free_hit) begin
                            wr_en   = 1'b1;
                            wr_addr = r_free_slot;
                            cnt_inc = 1'b1;
                        end else begin
                            apply_status = STS_FULL;
                        end
                    end
                    CMD_POP: begin
                        wr_addr = r_head_slot;
                        if (r_head_hit) begin
                            wr_en   = 1'b1;
                            cnt_dec = 1'b1;
                        end else begin
                            apply_status = STS_EMPTY;
                        end
                    end
                    CMD_REMOVE: begin
                        wr_addr = r_match_slot;
                        if (r_match_hit) begin
                            wr_en   = 1'b1;
                            cnt_dec = 1'b1;
                        end else begin
                            apply_status = STS_NOT_FOUND;
                        end
                    end
                    CMD_STATUS: begin
                        apply_status = STS_OK;
                    end
                    default: apply_status = STS_OK;
                endcase
            end
            ST_DONE: begin
                load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_head_hit  <= 1'b0;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Advance the sweep or clearing address
            if (r_state == ST_CLEAR) begin
                r_addr <= r_addr + 1'b1;
            end else if (start_sweep) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
            end else if (scanning && r_issue) begin
                r_addr  <= r_addr + 1'b1;
                r_issue <= (r_addr != SLOT_LAST);
            end
            r_rd_vld <= scanning && r_issue;

            // Track id match and first free slot on the first sweep
            if (accept) begin
                r_match_hit <= 1'b0;
                r_free_hit  <= 1'b0;
            end else if (r_state == ST_SCAN1) begin
                if (match_now && !r_match_hit) r_match_hit <= 1'b1;
                if (free_now && !r_free_hit) r_free_hit <= 1'b1;
            end

            // Track the earliest entry on either sweep; pop keeps it
            if (start_sweep) begin
                r_head_hit <= 1'b0;
            end else if (scanning && head_now) begin
                r_head_hit <= 1'b1;
            end

            if (cnt_inc) r_count <= r_count + 1'b1;
            else if (cnt_dec) r_count <= r_count - 1'b1;

            // Hold the result beat until taken
            if (load_out) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) r_cmd <= i_in_data;
        r_rd_idx <= r_addr;

        if (r_state == ST_SCAN1) begin
            if (match_now && !r_match_hit) r_match_slot <= r_rd_idx;
            if (free_now && !r_free_hit) r_free_slot <= r_rd_idx;
        end

        if (scanning && head_now) begin
            r_head_slot <= r_rd_idx;
            r_head_dl   <= rd_slot.deadline;
            r_head_id   <= rd_slot.item_id;
        end

        if (r_state == ST_APPLY) r_status <= apply_status;

        if (load_out) begin
            r_out_data.status        <= r_status;
            r_out_data.head_deadline <= r_head_hit ? r_head_dl : '0;
            r_out_data.head_id       <= r_head_hit ? r_head_id : '0;
            r_out_data.head_valid    <= r_head_hit;
            r_out_data.entry_count   <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> tb/deadline_priority_queue_with_cancel_top_test.sv
// Self-checking bench for deadline_priority_queue_with_cancel_top: command beats
// come from a queue and responses are checked against a slot-level shadow of the queue.
// Depends on dpq_pkg and the block's RTL.
module deadline_priority_queue_with_cancel_top_test;
    import dpq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BEATS = 1500;
    localparam int ID_POOL      = 96;
    localparam int LIMIT_CYCLES = 1_500_000;
    // worst command latency plus margin, used for the final drain
    localparam int SETTLE       = 2 * CAPACITY + 8;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_cmd_beat in_data;
    logic      out_valid;
    logic      out_stall;
    t_rsp_beat out_data;

    // stimulus and expected responses
    t_cmd_beat cmd_queue[$];
    t_rsp_beat due_rsp[$];
    logic [ID_BITS-1:0] id_pool [ID_POOL];

    // shadow of the slot store
    logic [DEADLINE_BITS-1:0] shadow_deadline [CAPACITY];
    logic [ID_BITS-1:0]       shadow_id       [CAPACITY];
    logic                     shadow_used     [CAPACITY];
    int                       shadow_count;

    logic in_took;
    logic live;
    int   beats_in;
    int   beats_total;
    int   fails;
    int   rsp_checked;
    int   cmd_tally    [4];
    int   status_tally [4];

    deadline_priority_queue_with_cancel_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Slot of the earliest live entry, lowest slot on ties; -1 when empty
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int s = 0; s < CAPACITY; s++) begin
            if (shadow_used[s] && (best < 0 || shadow_deadline[s] < shadow_deadline[best]))
                best = s;
        end
        return best;
    endfunction

    function automatic int slot_of(logic [ID_BITS-1:0] id);
        for (int s = 0; s < CAPACITY; s++) begin
            if (shadow_used[s] && shadow_id[s] == id)
                return s;
        end
        return -1;
    endfunction

    // Apply one command to the shadow store and return the response it should produce
    function automatic t_rsp_beat run_command(t_cmd_beat b);
        t_rsp_beat r;
        int        hit;
        int        spot;
        r = '0;
        r.status = STS_OK;
        case (b.cmd)
            CMD_POP: begin
                hit = earliest_slot();
                if (hit < 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.head_deadline = shadow_deadline[hit];
                    r.head_id       = shadow_id[hit];
                    r.head_valid    = 1'b1;
                    shadow_used[hit] = 1'b0;
                    shadow_count--;
                end
            end
            CMD_ADD: begin
                hit = slot_of(b.item_id);
                if (hit >= 0) begin
                    // requeue of a known id: new deadline, same slot
                    shadow_deadline[hit] = b.deadline;
                end else begin
                    spot = -1;
                    for (int s = CAPACITY - 1; s >= 0; s--) begin
                        if (!shadow_used[s])
                            spot = s;
                    end
                    if (spot < 0) begin
                        r.status = STS_FULL;
                    end else begin
                        shadow_deadline[spot] = b.deadline;
                        shadow_id[spot]       = b.item_id;
                        shadow_used[spot]     = 1'b1;
                        shadow_count++;
                    end
                end
            end
            CMD_REMOVE: begin
                hit = slot_of(b.item_id);
                if (hit < 0) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    shadow_used[hit] = 1'b0;
                    shadow_count--;
                end
            end
            default: ;
        endcase
        // everything but a good pop reports the head after the command
        if (b.cmd != CMD_POP) begin
            hit = earliest_slot();
            if (hit >= 0) begin
                r.head_deadline = shadow_deadline[hit];
                r.head_id       = shadow_id[hit];
                r.head_valid    = 1'b1;
            end
        end
        r.entry_count = CNT_BITS'(shadow_count);
        cmd_tally[b.cmd]++;
        status_tally[r.status]++;
        return r;
    endfunction

    function automatic int sender_idle_pct();
        int phase;
        phase = (beats_in * 3) / beats_total;
        return (phase == 0) ? 34 : (phase == 1) ? 68 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        int phase;
        phase = (beats_in * 3) / beats_total;
        return (phase == 0) ? 68 : (phase == 1) ? 34 : 0;
    endfunction

    task automatic push_cmd(t_cmd c, logic [DEADLINE_BITS-1:0] dl, logic [ID_BITS-1:0] id);
        t_cmd_beat b;
        b.cmd      = c;
        b.deadline = dl;
        b.item_id  = id;
        cmd_queue.push_back(b);
    endtask

    // Tight deadlines force ties; wide ones cover every bit and both extremes
    function automatic logic [DEADLINE_BITS-1:0] pick_deadline(bit tight);
        logic [63:0] w;
        int          roll;
        if (tight)
            return DEADLINE_BITS'($urandom_range(0, 15));
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        w = {$urandom, $urandom};
        return w[DEADLINE_BITS-1:0];
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return id_pool[$urandom_range(0, ID_POOL - 1)];
    endfunction

    // Driver: load a new beat only once the current one has gone through
    always @(negedge clk) begin
        if (live && (!in_valid || in_took)) begin
            if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                in_valid <= 1'b1;
                in_data  <= cmd_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        if (live)
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end

    // Monitor: predict on each accepted command, check each accepted response
    always @(posedge clk) begin : monitor
        t_rsp_beat want;
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            due_rsp.push_back(run_command(in_data));
            beats_in++;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (due_rsp.size() == 0) begin
                $error("response with nothing outstanding: %p", out_data);
                fails++;
            end else begin
                want = due_rsp.pop_front();
                rsp_checked++;
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    fails++;
                end
                if (out_data.head_deadline !== want.head_deadline) begin
                    $error("head_deadline: expected %0h, got %0h",
                           want.head_deadline, out_data.head_deadline);
                    fails++;
                end
                if (out_data.head_id !== want.head_id) begin
                    $error("head_id: expected %0h, got %0h", want.head_id, out_data.head_id);
                    fails++;
                end
                if (out_data.head_valid !== want.head_valid) begin
                    $error("head_valid: expected %0b, got %0b",
                           want.head_valid, out_data.head_valid);
                    fails++;
                end
                if (out_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, out_data.entry_count);
                    fails++;
                end
            end
        end
    end

    initial begin
        int kind;
        int n;
        int base;
        int roll;
        bit tight;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        in_took     = 1'b0;
        live        = 1'b0;
        beats_in    = 0;
        fails       = 0;
        rsp_checked = 0;
        shadow_count = 0;
        for (int s = 0; s < CAPACITY; s++) begin
            shadow_used[s]     = 1'b0;
            shadow_deadline[s] = '0;
            shadow_id[s]       = '0;
        end
        for (int k = 0; k < 4; k++) begin
            cmd_tally[k]    = 0;
            status_tally[k] = 0;
        end
        for (int k = 0; k < ID_POOL; k++)
            id_pool[k] = $urandom;

        // Directed: empty queue, extremes, ties, requeue, misses, drain past empty
        push_cmd(CMD_STATUS, '1, '1);
        push_cmd(CMD_POP, '1, '1);
        push_cmd(CMD_REMOVE, '0, 32'd5);
        push_cmd(CMD_ADD, '1, '1);
        push_cmd(CMD_ADD, '0, '0);
        push_cmd(CMD_ADD, '0, 32'h0000_1234);
        push_cmd(CMD_STATUS, '0, '0);
        push_cmd(CMD_ADD, '1, '0);
        push_cmd(CMD_REMOVE, '0, 32'h0000_1234);
        push_cmd(CMD_REMOVE, '1, 32'd7);
        push_cmd(CMD_ADD, 48'h5555_5555_5555, 32'hAAAA_AAAA);
        push_cmd(CMD_ADD, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
        push_cmd(CMD_ADD, 48'h5555_5555_5555, 32'h0F0F_0F0F);
        push_cmd(CMD_POP, 48'h1234_5678_9ABC, 32'hDEAD_BEEF);
        push_cmd(CMD_POP, '0, '0);
        push_cmd(CMD_POP, '0, '0);
        push_cmd(CMD_POP, '0, '0);
        push_cmd(CMD_POP, '0, '0);
        push_cmd(CMD_POP, '0, '0);
        push_cmd(CMD_STATUS, '0, '1);

        // Random: fill bursts reach full, drains empty it, mixed and noise in between
        n = cmd_queue.size() + RANDOM_BEATS;
        while (cmd_queue.size() < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                base  = $urandom_range(0, ID_POOL - 1);
                tight = $urandom_range(0, 1);
                for (int k = $urandom_range(60, 90); k > 0; k--) begin
                    if ($urandom_range(0, 9) == 0)
                        push_cmd(CMD_STATUS, pick_deadline(0), pick_id());
                    else
                        push_cmd(CMD_ADD, pick_deadline(tight), id_pool[(base + k) % ID_POOL]);
                end
            end else if (kind < 5) begin
                for (int k = $urandom_range(30, 80); k > 0; k--) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 5)
                        push_cmd(CMD_POP, pick_deadline(0), pick_id());
                    else if (roll < 9)
                        push_cmd(CMD_REMOVE, pick_deadline(0), pick_id());
                    else
                        push_cmd(CMD_STATUS, pick_deadline(0), pick_id());
                end
            end else if (kind < 9) begin
                tight = $urandom_range(0, 1);
                for (int k = 0; k < 40; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 40)
                        push_cmd(CMD_ADD, pick_deadline(tight), pick_id());
                    else if (roll < 65)
                        push_cmd(CMD_POP, pick_deadline(0), pick_id());
                    else if (roll < 90)
                        push_cmd(CMD_REMOVE, pick_deadline(0), pick_id());
                    else
                        push_cmd(CMD_STATUS, pick_deadline(0), pick_id());
                end
            end else begin
                for (int k = 0; k < 15; k++)
                    push_cmd(t_cmd'($urandom_range(0, 3)), pick_deadline(0), $urandom);
            end
        end
        beats_total = cmd_queue.size();

        // Hold reset, then let the driver run
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        live  <= 1'b1;

        while (beats_in < beats_total || due_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Checked %0d responses: %0d add, %0d pop, %0d remove, %0d status commands.",
                 rsp_checked, cmd_tally[CMD_ADD], cmd_tally[CMD_POP],
                 cmd_tally[CMD_REMOVE], cmd_tally[CMD_STATUS]);
        $display("Outcomes: %0d ok, %0d pop on empty, %0d id not found, %0d queue full.",
                 status_tally[STS_OK], status_tally[STS_EMPTY],
                 status_tally[STS_NOT_FOUND], status_tally[STS_FULL]);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dpq_pkg.sv
hw/rtl/dpq_slot_ram.sv
hw/rtl/deadline_priority_queue_with_cancel_top.sv
tb/deadline_priority_queue_with_cancel_top_test.sv
